@@ src/ifr_pkg.sv @@
package ifr_pkg;

    // Input action, covariance kind and row codes
    localparam logic [1:0] ACT_VEC  = 2'd0;
    localparam logic [1:0] ACT_ORI  = 2'd1;
    localparam logic [1:0] ACT_COV  = 2'd2;
    localparam logic [1:0] KIND_ORI = 2'd2;
    localparam logic [1:0] ROW_LAST = 2'd2;
    localparam logic [1:0] ROW_BAD  = 2'd3;

    // Q2.30 conversion of nine-digit decimals, rounded half away from zero
    localparam longint Q30  = 64'sd1073741824;
    localparam longint Half = 64'sd500000000;
    localparam longint Dec  = 64'sd1000000000;

    // nominal roll/pitch/yaw matrix, row-major
    localparam longint MN0 = -((64'sd115699 * Q30 + Half) / Dec);
    localparam longint MN1 = -((64'sd115672 * Q30 + Half) / Dec);
    localparam longint MN2 = (64'sd999999987 * Q30 + Half) / Dec;
    localparam longint MN3 = -((64'sd999999967 * Q30 + Half) / Dec);
    localparam longint MN4 = (64'sd231410 * Q30 + Half) / Dec;
    localparam longint MN5 = -((64'sd115672 * Q30 + Half) / Dec);
    localparam longint MN6 = -((64'sd231397 * Q30 + Half) / Dec);
    localparam longint MN7 = -((64'sd999999967 * Q30 + Half) / Dec);
    localparam longint MN8 = -((64'sd115699 * Q30 + Half) / Dec);

    // calibrated matrix, row-major
    localparam longint MC0 = -((64'sd27632287 * Q30 + Half) / Dec);
    localparam longint MC1 = (64'sd269584365 * Q30 + Half) / Dec;
    localparam longint MC2 = (64'sd962580245 * Q30 + Half) / Dec;
    localparam longint MC3 = -((64'sd979731753 * Q30 + Half) / Dec);
    localparam longint MC4 = -((64'sd198424678 * Q30 + Half) / Dec);
    localparam longint MC5 = (64'sd27447022 * Q30 + Half) / Dec;
    localparam longint MC6 = (64'sd198398963 * Q30 + Half) / Dec;
    localparam longint MC7 = -((64'sd942312007 * Q30 + Half) / Dec);
    localparam longint MC8 = (64'sd269603290 * Q30 + Half) / Dec;

    // static quaternions (w, x, y, z)
    localparam longint QN0 = (64'sd500000003 * Q30 + Half) / Dec;
    localparam longint QN1 = -((64'sd499942144 * Q30 + Half) / Dec);
    localparam longint QN2 = (64'sd500115689 * Q30 + Half) / Dec;
    localparam longint QN3 = -((64'sd499942144 * Q30 + Half) / Dec);
    localparam longint QK0 = (64'sd510770575 * Q30 + Half) / Dec;
    localparam longint QK1 = -((64'sd474654900 * Q30 + Half) / Dec);
    localparam longint QK2 = (64'sd374033530 * Q30 + Half) / Dec;
    localparam longint QK3 = -((64'sd611486000 * Q30 + Half) / Dec);

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL,
        OP_WB,
        OP_PASS,
        OP_CPASS,
        OP_SCALE,
        OP_SQRT,
        OP_DINIT,
        OP_DSTEP,
        OP_DWB,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        PH_VEC,
        PH_SQ,
        PH_QM,
        PH_CT,
        PH_CO,
        PH_OPASS,
        PH_CPASS
    } phase_t;

    typedef struct packed {
        logic       take;
        op_t        op;
        phase_t     phase;
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] k;
        logic       em_ok;
        logic       em_last;
        logic [1:0] em_row;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic [1:0] kind;
        logic [1:0] row;
        logic       nf;
        logic       zero;
        logic       lov;
        logic       scale_done;
        logic       out_free;
    } dp_stat_t;

    // rotation matrix element
    function automatic logic signed [31:0] r_coef(input logic cal, input logic [3:0] idx);
        logic signed [31:0] v;
        v = '0;
        if (cal)
        begin
            case (idx)
                4'd0: v = 32'(MC0);
                4'd1: v = 32'(MC1);
                4'd2: v = 32'(MC2);
                4'd3: v = 32'(MC3);
                4'd4: v = 32'(MC4);
                4'd5: v = 32'(MC5);
                4'd6: v = 32'(MC6);
                4'd7: v = 32'(MC7);
                4'd8: v = 32'(MC8);
                default: v = '0;
            endcase
        end
        else
        begin
            case (idx)
                4'd0: v = 32'(MN0);
                4'd1: v = 32'(MN1);
                4'd2: v = 32'(MN2);
                4'd3: v = 32'(MN3);
                4'd4: v = 32'(MN4);
                4'd5: v = 32'(MN5);
                4'd6: v = 32'(MN6);
                4'd7: v = 32'(MN7);
                4'd8: v = 32'(MN8);
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    // static quaternion component, order w x y z
    function automatic logic signed [31:0] s_coef(input logic cal, input logic [1:0] idx);
        logic signed [31:0] v;
        v = '0;
        case ({cal, idx})
            3'b000: v = 32'(QN0);
            3'b001: v = 32'(QN1);
            3'b010: v = 32'(QN2);
            3'b011: v = 32'(QN3);
            3'b100: v = 32'(QK0);
            3'b101: v = 32'(QK1);
            3'b110: v = 32'(QK2);
            3'b111: v = 32'(QK3);
            default: v = '0;
        endcase
        return v;
    endfunction

    // sign of term k in component i of the product with the conjugate
    function automatic logic q_neg(input logic [1:0] i, input logic [1:0] k);
        logic n;
        n = 1'b0;
        case (i)
            2'd0: n = 1'b0;
            2'd1: n = (k == 2'd0) || (k == 2'd2);
            2'd2: n = (k == 2'd0) || (k == 2'd3);
            2'd3: n = (k == 2'd0) || (k == 2'd1);
            default: n = 1'b0;
        endcase
        return n;
    endfunction

endpackage

@@ src/imu_frame_rotation_top.sv @@
// IMU sensor-to-body frame rotation.
// Input channel (in_valid/in_stall) carries one request: a vector, an
// orientation quaternion or one covariance row, all Q16.16. Output channel
// (out_valid/out_stall) carries results; the third covariance row gives
// three results, row_out 0..2, last on the third.
// cfg_we/cfg_data write the matrix select (1 calibrated, 0 nominal matrix).
// One request is in work at a time; in_stall is high after acceptance until
// its last result is loaded into the output register; covariance rows 0/1
// give no result and release in_stall after decode. The work is done by the
// single shared 34x32 multiply-accumulate unit, the bit-serial square root
// and the bit-serial divider. A valid orientation is scaled, then goes
// through the sum of squares, the square root, four divides and the
// quaternion product; an invalid orientation is passed through, and so is
// the final orientation covariance row when no valid orientation is on record.
// The output register holds a result while out_stall is high; the block
// then waits before loading the next one, and may accept a new request once
// the last result is loaded. Reset clears the sequencer, the output valid,
// the orientation flag and selects the calibrated matrix; the covariance
// buffer holds no reset value.
module imu_frame_rotation_top
    import ifr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [1:0]         cov_kind,
    input  logic [1:0]         row_index,
    input  logic signed [31:0] comp_x,
    input  logic signed [31:0] comp_y,
    input  logic signed [31:0] comp_z,
    input  logic signed [31:0] comp_w,
    input  logic               not_finite,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic signed [31:0] res_z,
    output logic signed [31:0] res_w,
    output logic               orientation_ok,
    output logic [1:0]         row_out,
    output logic               last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    ifr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and storage
    ifr_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .action         (action),
        .cov_kind       (cov_kind),
        .row_index      (row_index),
        .comp_x         (comp_x),
        .comp_y         (comp_y),
        .comp_z         (comp_z),
        .comp_w         (comp_w),
        .not_finite     (not_finite),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .res_x          (res_x),
        .res_y          (res_y),
        .res_z          (res_z),
        .res_w          (res_w),
        .orientation_ok (orientation_ok),
        .row_out        (row_out),
        .last           (last)
    );

endmodule

@@ src/ifr_dpath.sv @@
module ifr_dpath
    import ifr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic [1:0]         action,
    input  logic [1:0]         cov_kind,
    input  logic [1:0]         row_index,
    input  logic signed [31:0] comp_x,
    input  logic signed [31:0] comp_y,
    input  logic signed [31:0] comp_z,
    input  logic signed [31:0] comp_w,
    input  logic               not_finite,
    input  logic               out_stall,
    output logic               out_valid,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic signed [31:0] res_z,
    output logic signed [31:0] res_w,
    output logic               orientation_ok,
    output logic [1:0]         row_out,
    output logic               last
);

    // round half away from zero
    function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v, input int sh);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    logic               use_cal_reg;
    logic               lov_reg;
    logic [1:0]         act_reg, kind_reg, row_reg;
    logic               nf_reg;
    logic signed [31:0] c_reg [4];
    logic [31:0]        a_reg [4];
    logic               neg_reg [4];
    logic signed [31:0] b_reg [4];
    logic signed [31:0] cov_reg [9];
    logic signed [33:0] t_reg [9];
    logic signed [31:0] wk_reg [4];
    logic signed [63:0] mul_reg;
    logic               mul_vld_reg, mul_sub_reg;
    logic signed [63:0] acc_reg;
    logic [63:0]        sq_n_reg, sq_r_reg, sq_bit_reg;
    logic [31:0]        rem_reg, lo_reg, quo_reg;
    logic signed [31:0] o_reg [4];
    logic               o_ok_reg, o_last_reg, o_vld_reg;
    logic [1:0]         o_row_reg;

    // shared address arithmetic
    logic [3:0] idx_ik, idx_jk, idx_kj, idx_ij;
    assign idx_ik = 4'(cmd.i) * 4'd3 + 4'(cmd.k);
    assign idx_jk = 4'(cmd.j) * 4'd3 + 4'(cmd.k);
    assign idx_kj = 4'(cmd.k) * 4'd3 + 4'(cmd.j);
    assign idx_ij = 4'(cmd.i) * 4'd3 + 4'(cmd.j);

    // single buffer read port
    logic [3:0]         cov_idx;
    logic signed [31:0] cov_rd;
    assign cov_idx = (cmd.phase == PH_CPASS) ? idx_ik : idx_kj;
    assign cov_rd  = cov_reg[cov_idx];

    // multiplier operand selection
    logic signed [33:0] opa;
    logic signed [31:0] opb;
    logic signed [65:0] prod;
    always_comb
    begin
        opa = '0;
        opb = '0;
        case (cmd.phase)
            PH_VEC:
            begin
                opa = 34'(c_reg[cmd.k]);
                opb = r_coef(use_cal_reg, idx_ik);
            end
            PH_SQ:
            begin
                opa = $signed({2'b00, a_reg[cmd.k]});
                opb = $signed(a_reg[cmd.k]);
            end
            PH_QM:
            begin
                opa = 34'(b_reg[cmd.k]);
                opb = s_coef(use_cal_reg, cmd.i ^ cmd.k);
            end
            PH_CT:
            begin
                opa = 34'(cov_rd);
                opb = r_coef(use_cal_reg, idx_ik);
            end
            PH_CO:
            begin
                opa = t_reg[idx_ik];
                opb = r_coef(use_cal_reg, idx_jk);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end
    assign prod = opa * opb;

    // largest magnitude for scaling
    logic [31:0] m01, m23, mx;
    assign m01 = (a_reg[0] > a_reg[1]) ? a_reg[0] : a_reg[1];
    assign m23 = (a_reg[2] > a_reg[3]) ? a_reg[2] : a_reg[3];
    assign mx  = (m01 > m23) ? m01 : m23;
    logic sc_down, sc_done;
    assign sc_down = mx[31] | mx[30];
    assign sc_done = !sc_down && mx[29];

    // square root step
    logic [63:0] sq_trial;
    assign sq_trial = sq_r_reg + sq_bit_reg;

    // divider step and set-up
    logic [31:0] nrm;
    logic [61:0] num;
    logic [32:0] rem2;
    logic        div_ge;
    assign nrm    = sq_r_reg[31:0];
    assign num    = 62'({a_reg[cmd.i], 30'd0}) + 62'(nrm >> 1);
    assign rem2   = {rem_reg, lo_reg[31]};
    assign div_ge = rem2 >= {1'b0, nrm};

    // write-back values
    logic signed [63:0] r30, r44;
    assign r30 = rnd_sh(acc_reg, 30);
    assign r44 = rnd_sh(acc_reg, 44);

    logic [1:0] qm_slot;
    assign qm_slot = cmd.i - 2'd1;

    logic out_free;
    assign out_free = !o_vld_reg || !out_stall;

    // configuration and orientation flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_cal_reg <= 1'b1;
            lov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                use_cal_reg <= cfg_data;
            if (cmd.op == OP_PASS)
                lov_reg <= 1'b0;
            else if (cmd.op == OP_EMIT && cmd.em_ok)
                lov_reg <= 1'b1;
        end
    end

    // multiply-accumulate pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_vld_reg <= 1'b0;
        else
            mul_vld_reg <= (cmd.op == OP_MUL);
    end

    // request capture and covariance row store
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            act_reg  <= action;
            kind_reg <= cov_kind;
            row_reg  <= row_index;
            nf_reg   <= not_finite;
            c_reg[0] <= comp_x;
            c_reg[1] <= comp_y;
            c_reg[2] <= comp_z;
            c_reg[3] <= comp_w;
            // magnitudes in order w x y z
            a_reg[0]   <= comp_w[31] ? 32'(-comp_w) : comp_w;
            a_reg[1]   <= comp_x[31] ? 32'(-comp_x) : comp_x;
            a_reg[2]   <= comp_y[31] ? 32'(-comp_y) : comp_y;
            a_reg[3]   <= comp_z[31] ? 32'(-comp_z) : comp_z;
            neg_reg[0] <= comp_w[31];
            neg_reg[1] <= comp_x[31];
            neg_reg[2] <= comp_y[31];
            neg_reg[3] <= comp_z[31];
            for (int n = 0; n < 4; n++)
                wk_reg[n] <= '0;
            if (action == ACT_COV && row_index != ROW_BAD)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    if (row_index == 2'(r))
                    begin
                        cov_reg[r * 3]     <= comp_x;
                        cov_reg[r * 3 + 1] <= comp_y;
                        cov_reg[r * 3 + 2] <= comp_z;
                    end
                end
            end
        end
        else if (cmd.op == OP_SCALE && !sc_done)
        begin
            for (int n = 0; n < 4; n++)
                a_reg[n] <= sc_down ? (a_reg[n] >> 1) : (a_reg[n] << 1);
        end

        // multiplier and accumulator
        mul_reg     <= prod[63:0];
        mul_sub_reg <= (cmd.phase == PH_QM) && q_neg(cmd.i, cmd.k);
        if (cmd.take || cmd.op == OP_WB)
            acc_reg <= '0;
        else if (mul_vld_reg)
            acc_reg <= mul_sub_reg ? acc_reg - mul_reg : acc_reg + mul_reg;

        // write-back of a finished sum
        if (cmd.op == OP_WB)
        begin
            case (cmd.phase)
                PH_VEC: wk_reg[cmd.i] <= sat32(-r30);
                PH_SQ:
                begin
                    sq_n_reg   <= acc_reg;
                    sq_r_reg   <= '0;
                    sq_bit_reg <= 64'h4000_0000_0000_0000;
                end
                PH_QM: wk_reg[qm_slot] <= sat32(r44);
                PH_CT: t_reg[idx_ij] <= r30[33:0];
                PH_CO: wk_reg[cmd.j] <= sat32(r30);
                default: ;
            endcase
        end

        // pass-through copies
        if (cmd.op == OP_PASS)
        begin
            for (int n = 0; n < 4; n++)
                wk_reg[n] <= c_reg[n];
        end
        if (cmd.op == OP_CPASS)
            wk_reg[cmd.k] <= cov_rd;

        // integer square root, one result bit a cycle
        if (cmd.op == OP_SQRT)
        begin
            if (sq_n_reg >= sq_trial)
            begin
                sq_n_reg <= sq_n_reg - sq_trial;
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end
            else
                sq_r_reg <= sq_r_reg >> 1;
            sq_bit_reg <= sq_bit_reg >> 2;
        end

        // restoring division, one quotient bit a cycle
        if (cmd.op == OP_DINIT)
        begin
            rem_reg <= 32'(num[61:32]);
            lo_reg  <= num[31:0];
            quo_reg <= '0;
        end
        if (cmd.op == OP_DSTEP)
        begin
            rem_reg <= div_ge ? 32'(rem2 - {1'b0, nrm}) : rem2[31:0];
            lo_reg  <= lo_reg << 1;
            quo_reg <= {quo_reg[30:0], div_ge};
        end
        if (cmd.op == OP_DWB)
            b_reg[cmd.i] <= neg_reg[cmd.i] ? -$signed(quo_reg) : $signed(quo_reg);

        // output register payload
        if (cmd.op == OP_EMIT)
        begin
            for (int n = 0; n < 4; n++)
                o_reg[n] <= wk_reg[n];
            o_ok_reg   <= cmd.em_ok;
            o_last_reg <= cmd.em_last;
            o_row_reg  <= cmd.em_row;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else if (cmd.op == OP_EMIT)
            o_vld_reg <= 1'b1;
        else if (!out_stall)
            o_vld_reg <= 1'b0;
    end

    assign stat.act        = act_reg;
    assign stat.kind       = kind_reg;
    assign stat.row        = row_reg;
    assign stat.nf         = nf_reg;
    assign stat.zero       = (c_reg[0] == 0) && (c_reg[1] == 0) && (c_reg[2] == 0)
                             && (c_reg[3] == 0);
    assign stat.lov        = lov_reg;
    assign stat.scale_done = sc_done;
    assign stat.out_free   = out_free;

    assign out_valid      = o_vld_reg;
    assign res_x          = o_reg[0];
    assign res_y          = o_reg[1];
    assign res_z          = o_reg[2];
    assign res_w          = o_reg[3];
    assign orientation_ok = o_ok_reg;
    assign row_out        = o_row_reg;
    assign last           = o_last_reg;

endmodule

@@ src/ifr_ctrl.sv @@
module ifr_ctrl
    import ifr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DECODE = 13'b0000000000010,
        S_DOT    = 13'b0000000000100,
        S_DRAIN  = 13'b0000000001000,
        S_WB     = 13'b0000000010000,
        S_SCALE  = 13'b0000000100000,
        S_SQRT   = 13'b0000001000000,
        S_DINIT  = 13'b0000010000000,
        S_DSTEP  = 13'b0000100000000,
        S_DWB    = 13'b0001000000000,
        S_PASS   = 13'b0010000000000,
        S_CPASS  = 13'b0100000000000,
        S_EMIT   = 13'b1000000000000
    } state_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [4:0] cnt_reg, cnt_next;

    logic [1:0] k_top;
    logic       row_phase;
    assign k_top     = (phase_reg == PH_SQ || phase_reg == PH_QM) ? 2'd3 : 2'd2;
    assign row_phase = (phase_reg == PH_CO) || (phase_reg == PH_CPASS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_VEC;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
        end
    end

    // sequencing
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        cmd.take    = 1'b0;
        cmd.op      = OP_NOP;
        cmd.phase   = phase_reg;
        cmd.i       = i_reg;
        cmd.j       = j_reg;
        cmd.k       = k_reg;
        cmd.em_ok   = (phase_reg == PH_QM);
        cmd.em_last = row_phase ? (i_reg == 2'd2) : 1'b1;
        cmd.em_row  = row_phase ? i_reg : 2'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
                case (stat.act)
                    ACT_VEC:
                    begin
                        phase_next = PH_VEC;
                        state_next = S_DOT;
                    end
                    ACT_ORI:
                    begin
                        if (stat.nf || stat.zero)
                        begin
                            phase_next = PH_OPASS;
                            state_next = S_PASS;
                        end
                        else
                            state_next = S_SCALE;
                    end
                    ACT_COV:
                    begin
                        if (stat.row != ROW_LAST)
                            state_next = S_IDLE;
                        else if (stat.kind == KIND_ORI && !stat.lov)
                        begin
                            phase_next = PH_CPASS;
                            state_next = S_CPASS;
                        end
                        else
                        begin
                            phase_next = PH_CT;
                            state_next = S_DOT;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_DOT:
            begin
                cmd.op = OP_MUL;
                if (k_reg == k_top)
                begin
                    k_next     = '0;
                    state_next = S_DRAIN;
                end
                else
                    k_next = k_reg + 2'd1;
            end
            S_DRAIN: state_next = S_WB;
            S_WB:
            begin
                cmd.op = OP_WB;
                case (phase_reg)
                    PH_VEC:
                    begin
                        if (i_reg == 2'd2)
                            state_next = S_EMIT;
                        else
                        begin
                            i_next     = i_reg + 2'd1;
                            state_next = S_DOT;
                        end
                    end
                    PH_SQ:
                    begin
                        cnt_next   = '0;
                        state_next = S_SQRT;
                    end
                    PH_QM:
                    begin
                        if (i_reg == 2'd3)
                            state_next = S_EMIT;
                        else
                        begin
                            i_next     = i_reg + 2'd1;
                            state_next = S_DOT;
                        end
                    end
                    PH_CT:
                    begin
                        state_next = S_DOT;
                        if (j_reg == 2'd2)
                        begin
                            j_next = '0;
                            if (i_reg == 2'd2)
                            begin
                                i_next     = '0;
                                phase_next = PH_CO;
                            end
                            else
                                i_next = i_reg + 2'd1;
                        end
                        else
                            j_next = j_reg + 2'd1;
                    end
                    PH_CO:
                    begin
                        if (j_reg == 2'd2)
                            state_next = S_EMIT;
                        else
                        begin
                            j_next     = j_reg + 2'd1;
                            state_next = S_DOT;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_SCALE:
            begin
                cmd.op = OP_SCALE;
                if (stat.scale_done)
                begin
                    phase_next = PH_SQ;
                    i_next     = '0;
                    k_next     = '0;
                    state_next = S_DOT;
                end
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    i_next     = '0;
                    state_next = S_DINIT;
                end
            end
            S_DINIT:
            begin
                cmd.op     = OP_DINIT;
                cnt_next   = '0;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.op   = OP_DSTEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = S_DWB;
            end
            S_DWB:
            begin
                cmd.op = OP_DWB;
                if (i_reg == 2'd3)
                begin
                    phase_next = PH_QM;
                    i_next     = '0;
                    k_next     = '0;
                    state_next = S_DOT;
                end
                else
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = S_DINIT;
                end
            end
            S_PASS:
            begin
                cmd.op     = OP_PASS;
                state_next = S_EMIT;
            end
            S_CPASS:
            begin
                cmd.op = OP_CPASS;
                if (k_reg == 2'd2)
                begin
                    k_next     = '0;
                    state_next = S_EMIT;
                end
                else
                    k_next = k_reg + 2'd1;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                    if (row_phase && i_reg != 2'd2)
                    begin
                        i_next     = i_reg + 2'd1;
                        j_next     = '0;
                        k_next     = '0;
                        state_next = (phase_reg == PH_CO) ? S_DOT : S_CPASS;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule
